@@ hdl/rma_pkg.sv @@
// Package for the range map allocator: command codes, word types and constants.
// Used by every module in hdl/.
`default_nettype none
package rma_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int ALIGN_W = 31;

   typedef enum logic [1:0] {
      CMD_FREE   = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_TOTALS = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [63:0]        req_addr;
      logic [63:0]        req_size;
      logic [ALIGN_W-1:0] align;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] result_addr;
      logic [63:0] found_limit;
      logic        lost;
      logic [63:0] total_free;
      logic [63:0] top_of_map;
   } rsp_word_type;

   // one table entry as it moves between cells
   typedef struct packed {
      logic [63:0] start;
      logic [63:0] length;
   } entry_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_SCAN,
      ST_FREE_DEC,
      ST_DROP,
      ST_ALIGN,
      ST_ALLOC_CHK,
      ST_GAP,
      ST_OUT
   } state_type;

   // per-cycle command to the row of cells
   typedef struct packed {
      logic      load;     // write entry at index sel
      logic      shl;      // entries above sel move down one slot
      logic      shr;      // entries from sel move up one slot
      logic      clear_top;
      entry_type wdata;
   } cell_ctl_type;

endpackage
`default_nettype wire

@@ hdl/rma_cell.sv @@
// One table slot: holds a start/length pair and takes a neighbor's entry on shifts.
// Depends on rma_pkg.
`default_nettype none
module rma_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  sel_here,    // this slot is the write target
   input  wire                  at_or_above, // slot index >= target
   input  wire                  above,       // slot index > target
   input  wire                  is_top,      // slot index == count-1 (for clear)
   input  wire rma_pkg::cell_ctl_type ctl,
   input  wire rma_pkg::entry_type    from_lower,
   input  wire rma_pkg::entry_type    from_upper,
   output rma_pkg::entry_type         q
);
   rma_pkg::entry_type data_ff, data_in;

   // next value: load wins, then shifts, then clear
   always_comb begin
      data_in = data_ff;
      if (ctl.load && sel_here) begin
         data_in = ctl.wdata;
      end else if (ctl.shr && above) begin
         data_in = from_lower;
      end else if (ctl.shl && at_or_above) begin
         data_in = from_upper;
      end else if (ctl.clear_top && is_top) begin
         data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;
endmodule
`default_nettype wire

@@ hdl/rma_divider.sv @@
// Radix-2 remainder unit: 64-bit value modulo 31-bit divisor, one bit per cycle.
// Depends on rma_pkg.
`default_nettype none
module rma_divider (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [63:0]                  dividend,
   input  wire [rma_pkg::ALIGN_W-1:0]  divisor,
   output logic                        done,
   output logic [rma_pkg::ALIGN_W-1:0] remainder
);
   logic [63:0]               quo_ff, quo_in;
   logic [rma_pkg::ALIGN_W:0] rem_ff, rem_in;
   logic [6:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [rma_pkg::ALIGN_W:0] trial;

   // shift one dividend bit in, subtract when it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[rma_pkg::ALIGN_W-1:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 7'd1);
   assign remainder = rem_in[rma_pkg::ALIGN_W-1:0];
endmodule
`default_nettype wire

@@ hdl/range_map_allocator_top.sv @@
// Top level of the range map allocator: sequencer, row of table cells, divider.
// Depends on rma_pkg, rma_cell and rma_divider.
//
// Usage: a command word (free, allocate, lookup, totals) is offered on req_
// with req_valid; it is taken when req_stall is low. One response word per
// command appears on rsp_ with rsp_valid and stays until rsp_stall is low.
// One command is worked at a time; req_stall is high from accept until the
// sequencer is idle again. A free walks the table one entry per cycle and a
// merge or insert shifts the whole row of cells at once. Lookup and totals
// walk the table entry by entry. An allocate tries the entries in turn; when
// alignment is set the remainder unit runs for each entry it tries, and one
// more free walk puts the leading gap back.
// The response moves into an output register, so the next command is taken
// while it waits; a stalled receiver holds the following response in the
// sequencer's last step and the input stalls behind it.
// Reset empties the table at once (every cell clears); no clearing pass.
`default_nettype none
module range_map_allocator_top #(
   parameter int ENTRIES = rma_pkg::ENTRIES_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire rma_pkg::req_word_type  req_word,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output rma_pkg::rsp_word_type       rsp_word
);
   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);
   localparam logic [63:0]   ONES = '1;

   rma_pkg::state_type state_ff, state_in;
   rma_pkg::req_word_type cmd_ff, cmd_in;
   rma_pkg::rsp_word_type rsp_ff, rsp_in;
   rma_pkg::rsp_word_type out_ff, out_in;
   logic              rv_ff, rv_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     idx_ff, idx_in;
   // free operands (also used for the allocation gap)
   logic [63:0]       fa_ff, fa_in, fs_ff, fs_in;
   logic              gap_ff, gap_in;
   logic [63:0]       ms_ff, ms_in;
   rma_pkg::cell_ctl_type ctl;
   logic [IW-1:0]     sel;
   rma_pkg::entry_type q [ENTRIES];
   rma_pkg::entry_type cur, prv;
   logic [63:0]       cur_end, prv_end, a_end;
   logic              div_start, div_done;
   logic [rma_pkg::ALIGN_W-1:0] div_rem;
   logic [63:0]       step, end_a;

   // row of cells, each shifting against its neighbors
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      rma_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .sel_here    (IW'(g) == sel),
         .at_or_above (IW'(g) >= sel),
         .above       (IW'(g) > sel),
         .is_top      (CW'(g) == cnt_ff - CW'(1)),
         .ctl         (ctl),
         .from_lower  (q[(g == 0) ? 0 : g - 1]),
         .from_upper  ((g == ENTRIES - 1) ? rma_pkg::entry_type'('0) :
                       q[(g == ENTRIES - 1) ? g : g + 1]),
         .q           (q[g])
      );
   end

   rma_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (ms_ff),
      .divisor   (cmd_ff.align),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign cur     = q[idx_ff[IW-1:0]];
   assign prv     = q[(idx_ff == '0) ? '0 : idx_ff[IW-1:0] - IW'(1)];
   assign cur_end = cur.start + cur.length;
   assign prv_end = prv.start + prv.length;
   assign a_end   = fa_ff + fs_ff;
   assign end_a   = cur_end;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      rsp_in    = rsp_ff;
      out_in    = out_ff;
      rv_in     = rv_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      fa_in     = fa_ff;
      fs_in     = fs_ff;
      gap_in    = gap_ff;
      ms_in     = ms_ff;
      ctl       = '0;
      sel       = idx_ff[IW-1:0];
      div_start = 1'b0;
      step      = '0;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         rma_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_word;
               rsp_in = '0;
               idx_in = '0;
               fa_in  = req_word.req_addr;
               fs_in  = req_word.req_size;
               gap_in = 1'b0;
               unique case (rma_pkg::cmd_type'(req_word.command))
                  rma_pkg::CMD_FREE:  state_in = rma_pkg::ST_CLIP;
                  rma_pkg::CMD_ALLOC: state_in = (req_word.req_size == '0) ?
                                                 rma_pkg::ST_OUT : rma_pkg::ST_SCAN;
                  default:            state_in = rma_pkg::ST_SCAN;
               endcase
            end
         end
         rma_pkg::ST_CLIP: begin
            // clip at the top of space, drop empty frees
            if (fs_ff > ONES - fa_ff) begin
               fs_in = ONES - fa_ff;
            end
            idx_in = '0;
            if (fs_ff == '0 || fa_ff == ONES) begin
               state_in = rma_pkg::ST_OUT;
            end else begin
               state_in = rma_pkg::ST_FREE_DEC;
            end
         end
         rma_pkg::ST_FREE_DEC: begin
            // walk to first entry starting past the address, then merge or insert
            if (idx_ff < cnt_ff && cur.start <= fa_ff) begin
               idx_in = idx_ff + CW'(1);
            end else if (idx_ff != '0 && prv_end == fa_ff) begin
               sel       = idx_ff[IW-1:0] - IW'(1);
               ctl.load  = 1'b1;
               ctl.wdata = '{start: prv.start, length: prv.length + fs_ff};
               if (idx_ff < cnt_ff && a_end == cur.start) begin
                  ctl.wdata.length = prv.length + fs_ff + cur.length;
                  state_in = rma_pkg::ST_DROP;
               end else begin
                  state_in = rma_pkg::ST_OUT;
               end
            end else if (idx_ff < cnt_ff && a_end == cur.start) begin
               ctl.load  = 1'b1;
               ctl.wdata = '{start: fa_ff, length: cur.length + fs_ff};
               state_in  = rma_pkg::ST_OUT;
            end else if (idx_ff >= FULL) begin
               rsp_in.lost = 1'b1;
               state_in    = rma_pkg::ST_OUT;
            end else begin
               ctl.shr   = 1'b1;
               ctl.load  = 1'b1;
               ctl.wdata = '{start: fa_ff, length: fs_ff};
               if (cnt_ff >= FULL) begin
                  rsp_in.lost = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
               state_in = rma_pkg::ST_OUT;
            end
         end
         rma_pkg::ST_DROP: begin
            // remove entry idx by pulling the upper ones down
            ctl.shl = 1'b1;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1);
            end
            state_in = gap_ff ? rma_pkg::ST_GAP : rma_pkg::ST_OUT;
         end
         rma_pkg::ST_SCAN: begin
            unique case (rma_pkg::cmd_type'(cmd_ff.command))
               rma_pkg::CMD_LOOKUP: begin
                  if (idx_ff >= cnt_ff) begin
                     state_in = rma_pkg::ST_OUT;
                  end else if (cur.start <= cmd_ff.req_addr && cmd_ff.req_addr < cur_end) begin
                     rsp_in.ok          = 1'b1;
                     rsp_in.result_addr = cmd_ff.req_addr;
                     rsp_in.found_limit = cur_end;
                     state_in           = rma_pkg::ST_OUT;
                  end else begin
                     idx_in = idx_ff + CW'(1);
                  end
               end
               rma_pkg::CMD_TOTALS: begin
                  if (idx_ff >= cnt_ff) begin
                     state_in = rma_pkg::ST_OUT;
                  end else begin
                     rsp_in.total_free = rsp_ff.total_free + cur.length;
                     rsp_in.top_of_map = cur_end;
                     idx_in            = idx_ff + CW'(1);
                  end
               end
               default: begin
                  // allocate: fixed start check on entry idx, or its start when no address is given
                  if (idx_ff >= cnt_ff) begin
                     state_in = rma_pkg::ST_OUT;
                  end else if (cmd_ff.req_addr != '0) begin
                     if (cur.start > cmd_ff.req_addr) begin
                        state_in = rma_pkg::ST_OUT;
                     end else if (cmd_ff.req_addr - cur.start >= cur.length) begin
                        idx_in = idx_ff + CW'(1);
                     end else if (cmd_ff.req_size >
                                  cur.length - (cmd_ff.req_addr - cur.start)) begin
                        state_in = rma_pkg::ST_OUT;
                     end else begin
                        ms_in    = cmd_ff.req_addr;
                        state_in = rma_pkg::ST_ALIGN;
                     end
                  end else begin
                     ms_in    = cur.start;
                     state_in = rma_pkg::ST_ALIGN;
                  end
               end
            endcase
         end
         rma_pkg::ST_ALIGN: begin
            if (cmd_ff.align == '0) begin
               state_in = rma_pkg::ST_ALLOC_CHK;
            end else begin
               div_start = 1'b1;
               state_in  = rma_pkg::ST_ALLOC_CHK;
               gap_in    = 1'b1; // marks divider running
            end
         end
         rma_pkg::ST_ALLOC_CHK: begin
            if (gap_ff && !div_done) begin
               state_in = rma_pkg::ST_ALLOC_CHK;
            end else begin
               gap_in = 1'b0;
               step   = (gap_ff && div_rem != '0) ?
                        64'(cmd_ff.align) - 64'(div_rem) : '0;
               if (step > end_a - ms_ff || end_a - (ms_ff + step) < cmd_ff.req_size) begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = rma_pkg::ST_SCAN;
               end else begin
                  rsp_in.ok          = 1'b1;
                  rsp_in.result_addr = ms_ff + step;
                  ctl.load           = 1'b1;
                  ctl.wdata          = '{start: ms_ff + step + cmd_ff.req_size,
                                         length: end_a - (ms_ff + step + cmd_ff.req_size)};
                  fa_in              = cur.start;
                  fs_in              = ms_ff + step - cur.start;
                  gap_in             = (ms_ff + step != cur.start);
                  if (end_a - (ms_ff + step + cmd_ff.req_size) == '0) begin
                     state_in = rma_pkg::ST_DROP;
                  end else begin
                     state_in = rma_pkg::ST_GAP;
                  end
               end
            end
         end
         rma_pkg::ST_GAP: begin
            // put the leading gap back through the free path
            idx_in = '0;
            if (gap_ff) begin
               gap_in   = 1'b0;
               state_in = rma_pkg::ST_CLIP;
            end else begin
               state_in = rma_pkg::ST_OUT;
            end
         end
         rma_pkg::ST_OUT: begin
            // hand the response to the output register once it is free
            if (!rv_ff || !rsp_stall) begin
               out_in   = rsp_ff;
               rv_in    = 1'b1;
               state_in = rma_pkg::ST_IDLE;
            end
         end
         default: state_in = rma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rma_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         cnt_ff   <= '0;
         gap_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         cnt_ff   <= cnt_in;
         gap_ff   <= gap_in;
      end
      cmd_ff   <= cmd_in;
      rsp_ff   <= rsp_in;
      out_ff   <= out_in;
      idx_ff   <= idx_in;
      fa_ff    <= fa_in;
      fs_ff    <= fs_in;
      ms_ff    <= ms_in;
   end

   assign req_stall = (state_ff != rma_pkg::ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word  = out_ff;
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for range_map_allocator_top: random and directed free, allocate,
// lookup and totals commands checked against a built-in model of the free range table.
// Depends on rma_pkg and the range_map_allocator_top RTL.
`default_nettype none
module testbench;

   localparam int NSLOT = rma_pkg::ENTRIES_DEFAULT;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rma_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rma_pkg::rsp_word_type rsp_word;

   range_map_allocator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   // model of the free range table
   logic [63:0] map_start [NSLOT];
   logic [63:0] map_len [NSLOT];
   int unsigned map_used;

   rma_pkg::req_word_type pending_words [$];
   rma_pkg::rsp_word_type expected_rsps [$];
   int fail_count = 0;
   bit stim_done = 1'b0;
   bit quiet_tail = 1'b0;
   bit hold_long = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void map_drop(int unsigned idx);
      for (int unsigned j = idx; j + 1 < map_used; j++) begin
         map_start[j] = map_start[j+1];
         map_len[j] = map_len[j+1];
      end
      if (map_used > 0) begin
         map_used--;
         map_start[map_used] = '0;
         map_len[map_used] = '0;
      end
   endfunction

   // insert a free range with merging; returns 1 when a piece falls off the table
   function automatic bit map_insert(logic [63:0] a, logic [63:0] s);
      int unsigned i, top;
      bit full;
      i = 0;
      if (s > ALL_ONES - a) s = ALL_ONES - a;
      if (s == 0) return 1'b0;
      while (i < map_used && map_start[i] <= a) i++;
      if (i > 0 && map_start[i-1] + map_len[i-1] == a) begin
         map_len[i-1] += s;
         if (i < map_used && a + s == map_start[i]) begin
            map_len[i-1] += map_len[i];
            map_drop(i);
         end
         return 1'b0;
      end
      if (i < map_used && a + s == map_start[i]) begin
         map_start[i] = a;
         map_len[i] += s;
         return 1'b0;
      end
      if (i >= NSLOT) return 1'b1;
      full = (map_used >= NSLOT);
      top = full ? NSLOT - 1 : map_used;
      for (int unsigned j = top; j > i; j--) begin
         map_start[j] = map_start[j-1];
         map_len[j] = map_len[j-1];
      end
      map_start[i] = a;
      map_len[i] = s;
      if (!full) map_used++;
      return full;
   endfunction

   // first-fit allocate; fills rsp ok/result_addr/lost
   function automatic void map_take(rma_pkg::req_word_type w, inout rma_pkg::rsp_word_type r);
      logic [63:0] a, s, al, ms, len, fin, orig, off, rem, step;
      a = w.req_addr;
      s = w.req_size;
      al = {33'd0, w.align};
      if (s == 0) return;
      for (int unsigned i = 0; i < map_used; i++) begin
         ms = map_start[i];
         len = map_len[i];
         fin = ms + len;
         if (a != 0) begin
            if (ms > a) return;
            off = a - ms;
            if (off >= len) continue;
            if (s > len - off) return;
            ms = a;
         end
         if (al != 0) begin
            rem = ms % al;
            if (rem != 0) begin
               step = al - rem;
               if (step > fin - ms) continue;
               ms += step;
            end
         end
         if (fin - ms < s) continue;
         orig = map_start[i];
         map_start[i] = ms + s;
         map_len[i] = fin - (ms + s);
         if (map_len[i] == 0) map_drop(i);
         if (ms != orig) r.lost = map_insert(orig, ms - orig);
         r.ok = 1'b1;
         r.result_addr = ms;
         return;
      end
   endfunction

   function automatic rma_pkg::rsp_word_type map_apply(rma_pkg::req_word_type w);
      rma_pkg::rsp_word_type r;
      logic [63:0] fin;
      r = '0;
      case (rma_pkg::cmd_type'(w.command))
         rma_pkg::CMD_FREE: begin
            r.lost = map_insert(w.req_addr, w.req_size);
         end
         rma_pkg::CMD_ALLOC: begin
            map_take(w, r);
         end
         rma_pkg::CMD_LOOKUP: begin
            for (int unsigned i = 0; i < map_used; i++) begin
               fin = map_start[i] + map_len[i];
               if (map_start[i] <= w.req_addr && w.req_addr < fin) begin
                  r.ok = 1'b1;
                  r.result_addr = w.req_addr;
                  r.found_limit = fin;
                  break;
               end
            end
         end
         default: begin
            for (int unsigned i = 0; i < map_used; i++) begin
               r.total_free += map_len[i];
               r.top_of_map = map_start[i] + map_len[i];
            end
         end
      endcase
      return r;
   endfunction

   function automatic rma_pkg::req_word_type mk(rma_pkg::cmd_type c, logic [63:0] a,
                                                logic [63:0] s,
                                                logic [rma_pkg::ALIGN_W-1:0] al);
      rma_pkg::req_word_type w;
      w.command = c;
      w.req_addr = a;
      w.req_size = s;
      w.align = al;
      return w;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // mostly small addresses so frees, merges and allocations interact
   function automatic rma_pkg::req_word_type random_word();
      rma_pkg::req_word_type w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      w = '0;
      if (pick < 3) begin
         w.command = 2'($urandom);
         w.req_addr = rnd64();
         w.req_size = rnd64();
         w.align = 31'($urandom);
         return w;
      end
      if (pick < 45) w.command = rma_pkg::CMD_FREE;
      else if (pick < 75) w.command = rma_pkg::CMD_ALLOC;
      else if (pick < 92) w.command = rma_pkg::CMD_LOOKUP;
      else w.command = rma_pkg::CMD_TOTALS;
      w.req_addr = 64'($urandom_range(0, 4095)) << 4;
      w.req_size = 64'($urandom_range(1, 64)) << $urandom_range(0, 6);
      if (w.command == rma_pkg::CMD_ALLOC && $urandom_range(0, 2) != 0) w.req_addr = '0;
      if (w.command == rma_pkg::CMD_ALLOC && $urandom_range(0, 1) == 1)
         w.align = 31'(1) << $urandom_range(0, 9);
      else if (w.command == rma_pkg::CMD_ALLOC && $urandom_range(0, 5) == 0)
         w.align = 31'($urandom_range(3, 200));
      if ($urandom_range(0, 15) == 0) w.req_addr = rnd64();
      if ($urandom_range(0, 15) == 0) w.req_size = rnd64();
      return w;
   endfunction

   // stimulus
   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         map_start[i] = '0;
         map_len[i] = '0;
      end
      map_used = 0;
      pending_words.push_back(mk(rma_pkg::CMD_TOTALS, 64'd0, 64'd0, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_LOOKUP, 64'd0, 64'd0, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'd0, 64'd16, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, 64'h1000, 64'd0, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, 64'h1000, 64'h100, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, 64'h1100, 64'h100, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, 64'h0F00, 64'h100, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, 64'h1080, 64'h40, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, ALL_ONES, 64'h10, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_FREE, ALL_ONES - 64'h20, ALL_ONES, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_LOOKUP, ALL_ONES - 64'd1, 64'd0, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'h1010, 64'h20, 31'h40));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'h0800, 64'h20, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'h1F00, 64'h200, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'd0, 64'h10, 31'h7FFF_FFFF));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'd0, 64'h8, 31'd3));
      pending_words.push_back(mk(rma_pkg::CMD_LOOKUP, 64'h1050, 64'd0, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_TOTALS, ALL_ONES, ALL_ONES, 31'h7FFF_FFFF));
      // fill past capacity with separated pieces
      for (int i = 0; i < 20; i++)
         pending_words.push_back(mk(rma_pkg::CMD_FREE, 64'h10_0000 + 64'(i) * 64'h100,
                                    64'h10, 31'd0));
      pending_words.push_back(mk(rma_pkg::CMD_ALLOC, 64'd0, 64'h10, 31'h100));
      pending_words.push_back(mk(rma_pkg::CMD_TOTALS, 64'd0, 64'd0, 31'd0));
      for (int i = 0; i < 1000; i++) pending_words.push_back(random_word());
   end

   // reset; the long receiver hold-off is in the monitor below
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned hold_count = 0;
   int unsigned received = 0;

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(map_apply(req_word));
         end
         if (req_valid && req_stall) begin
            // keep offering the stalled word
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               send_gap <= $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
         quiet_tail <= (pending_words.size() < 150);
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      rma_pkg::rsp_word_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            received <= received + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_word);
               fail_count++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (exp_r.ok !== rsp_word.ok)
                  $display("%0t: ok exp %h got %h", $time, exp_r.ok, rsp_word.ok);
               if (exp_r.result_addr !== rsp_word.result_addr)
                  $display("%0t: result_addr exp %h got %h", $time,
                           exp_r.result_addr, rsp_word.result_addr);
               if (exp_r.found_limit !== rsp_word.found_limit)
                  $display("%0t: found_limit exp %h got %h", $time,
                           exp_r.found_limit, rsp_word.found_limit);
               if (exp_r.lost !== rsp_word.lost)
                  $display("%0t: lost exp %h got %h", $time, exp_r.lost, rsp_word.lost);
               if (exp_r.total_free !== rsp_word.total_free)
                  $display("%0t: total_free exp %h got %h", $time,
                           exp_r.total_free, rsp_word.total_free);
               if (exp_r.top_of_map !== rsp_word.top_of_map)
                  $display("%0t: top_of_map exp %h got %h", $time,
                           exp_r.top_of_map, rsp_word.top_of_map);
               if (exp_r !== rsp_word) fail_count++;
            end
         end
         // long hold-off once, after some traffic
         if (!hold_long && received == 200 && hold_count == 0) begin
            hold_long <= 1'b1;
            hold_count <= 300;
            rsp_stall <= 1'b1;
         end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_stall <= (hold_count > 1);
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= (recv_gap > 1);
         end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            recv_gap <= $urandom_range(1, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (expected_rsps.size() == 0 && !rsp_valid);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0 && !rsp_valid)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
